// ----- rtl/core/ndiff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndiff_pkg
// shared types and constants of the nine-point diffusion step core
// ----------------------------------------------------------------------------
package ndiff_pkg;

  localparam int DEF_MAX_X = 64;
  localparam int DEF_MAX_Y = 64;

  // cell index width covering the largest lattice, coordinate width likewise
  localparam int IDX_W = 20;
  localparam int CRD_W = 11;
  localparam int ACC_W = 38;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_COMMIT  = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [7:0] CFG_SIZE_X = 8'd0;
  localparam logic [7:0] CFG_SIZE_Y = 8'd1;
  localparam logic [7:0] CFG_WRAP   = 8'd2;
  localparam logic [7:0] CFG_SCALE  = 8'd3;

  typedef enum logic [2:0] {
    K_LOAD,
    K_ECHO,
    K_ZERO,
    K_COMMIT,
    K_COPY,
    K_STENCIL
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              half;
    logic [31:0]       value;
    logic [IDX_W-1:0]  idx_c;
    logic [IDX_W-1:0]  idx_n;
    logic [IDX_W-1:0]  idx_s;
    logic [IDX_W-1:0]  idx_e;
    logic [IDX_W-1:0]  idx_w;
    logic [IDX_W-1:0]  idx_ne;
    logic [IDX_W-1:0]  idx_nw;
    logic [IDX_W-1:0]  idx_se;
    logic [IDX_W-1:0]  idx_sw;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_FIN,
    S_COPY,
    S_COPY_WB
  } state_t;

endpackage

// ----- rtl/core/ndiff_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndiff_front
// classifies an incoming item and works out its nine cell indices
// ----------------------------------------------------------------------------
module ndiff_front import ndiff_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y
) (
  input  logic [1:0]  op,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [31:0] cell_value,
  input  logic        half_step,
  input  logic [6:0]  size_x,
  input  logic [6:0]  size_y,
  input  logic        periodic_wrap,
  output entry_t      entry
);

  logic [CRD_W-1:0] sx, sy, x, y, xm, xp, ym, yp;
  logic [IDX_W-1:0] row_c, row_m, row_p;
  logic             in_lattice, edge_cell;

  always_comb begin
    if (size_x < 7'd3) begin
      sx = CRD_W'(3);
    end else if (CRD_W'(size_x) > CRD_W'(MAX_X)) begin
      sx = CRD_W'(MAX_X);
    end else begin
      sx = CRD_W'(size_x);
    end
    if (size_y < 7'd3) begin
      sy = CRD_W'(3);
    end else if (CRD_W'(size_y) > CRD_W'(MAX_Y)) begin
      sy = CRD_W'(MAX_Y);
    end else begin
      sy = CRD_W'(size_y);
    end
  end

  assign x = CRD_W'(cell_x);
  assign y = CRD_W'(cell_y);
  assign in_lattice = (x < sx) && (y < sy);
  assign edge_cell = (x == '0) || (y == '0) || (x == sx - 1'b1) || (y == sy - 1'b1);

  // periodic neighbours; inner cells never hit the wrap arms
  assign xm = (x == '0) ? sx - 1'b1 : x - 1'b1;
  assign xp = (x == sx - 1'b1) ? '0 : x + 1'b1;
  assign ym = (y == '0) ? sy - 1'b1 : y - 1'b1;
  assign yp = (y == sy - 1'b1) ? '0 : y + 1'b1;

  assign row_c = IDX_W'(y) * IDX_W'(MAX_X);
  assign row_m = IDX_W'(ym) * IDX_W'(MAX_X);
  assign row_p = IDX_W'(yp) * IDX_W'(MAX_X);

  always_comb begin
    entry.half   = half_step;
    entry.value  = cell_value;
    entry.idx_c  = row_c + IDX_W'(x);
    entry.idx_n  = row_m + IDX_W'(x);
    entry.idx_s  = row_p + IDX_W'(x);
    entry.idx_e  = row_c + IDX_W'(xp);
    entry.idx_w  = row_c + IDX_W'(xm);
    entry.idx_ne = row_m + IDX_W'(xp);
    entry.idx_nw = row_m + IDX_W'(xm);
    entry.idx_se = row_p + IDX_W'(xp);
    entry.idx_sw = row_p + IDX_W'(xm);
    unique case (op)
      OP_LOAD:    entry.kind = in_lattice ? K_LOAD : K_ECHO;
      OP_COMPUTE: begin
        if (!in_lattice) begin
          entry.kind = K_ZERO;
        end else if (edge_cell && !periodic_wrap) begin
          entry.kind = K_COPY;
        end else begin
          entry.kind = K_STENCIL;
        end
      end
      OP_COMMIT:  entry.kind = K_COMMIT;
      default:    entry.kind = K_ZERO;
    endcase
  end

endmodule

// ----- rtl/core/ndiff_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndiff_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module ndiff_queue import ndiff_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/core/ndiff_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndiff_back
// executes items against the double-buffered lattice and holds the result
// ----------------------------------------------------------------------------
module ndiff_back import ndiff_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y
) (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      q_head,
  input  logic        q_empty,
  output logic        pop,
  output logic        busy,
  input  logic [23:0] scale_factor,
  output logic        out_vld,
  input  logic        out_rdy,
  output logic [31:0] out_value,
  output logic        out_sat
);

  localparam int CELLS = MAX_X * MAX_Y;
  localparam int CW    = $clog2(CELLS);

  typedef enum logic [1:0] {W_M20, W_4, W_1, W_0} weight_t;

  // buffer select in the top address bit, so each half spans a power of two
  logic [31:0] mem [2**(CW+1)];

  state_t      state, state_next;
  entry_t      cur;
  logic        bsel;
  logic [2:0]  rd_cnt;
  logic        acc_vld;
  logic [2:0]  acc_pair;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      c_reg;
  logic [42:0]             prod_lo;
  logic signed [43:0]      prod_hi;
  logic signed [62:0]      prod;

  logic          we;
  logic [CW:0]   wr_addr, rd_addr_a, rd_addr_b;
  logic [31:0]   wr_data, rd_a, rd_b;
  logic [IDX_W-1:0] sel_a, sel_b;
  weight_t       wa, wb;
  logic signed [62:0] shifted;
  logic signed [63:0] total;
  logic          total_sat;
  logic [31:0]   total_val;

  function automatic logic signed [ACC_W-1:0] term(input logic [31:0] v, input weight_t w);
    logic signed [ACC_W-1:0] se;
    se = ACC_W'($signed(v));
    case (w)
      W_M20:   term = -(se <<< 4) - (se <<< 2);
      W_4:     term = se <<< 2;
      W_1:     term = se;
      default: term = '0;
    endcase
  endfunction

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  // read pairs of the stencil
  always_comb begin
    case (rd_cnt)
      3'd0:    begin sel_a = cur.idx_c;  sel_b = cur.idx_n;  end
      3'd1:    begin sel_a = cur.idx_s;  sel_b = cur.idx_e;  end
      3'd2:    begin sel_a = cur.idx_w;  sel_b = cur.idx_ne; end
      3'd3:    begin sel_a = cur.idx_nw; sel_b = cur.idx_se; end
      default: begin sel_a = cur.idx_sw; sel_b = cur.idx_c;  end
    endcase
    case (acc_pair)
      3'd0:    begin wa = W_M20; wb = W_4; end
      3'd1:    begin wa = W_4;   wb = W_4; end
      3'd2:    begin wa = W_4;   wb = W_1; end
      3'd3:    begin wa = W_1;   wb = W_1; end
      default: begin wa = W_1;   wb = W_0; end
    endcase
  end

  assign shifted   = cur.half ? (prod >>> 17) : (prod >>> 16);
  assign total     = 64'(shifted) + 64'(c_reg);
  assign total_sat = (total[63:31] != '0) && (total[63:31] != '1);
  assign total_val = !total_sat ? total[31:0] : (total[63] ? 32'h8000_0000 : 32'h7fff_ffff);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          if (q_head.kind == K_STENCIL) begin
            state_next = S_READ;
          end else if (q_head.kind == K_COPY) begin
            state_next = S_COPY;
          end
        end
      end
      S_READ:    if (rd_cnt == 3'd4) state_next = S_DRAIN;
      S_DRAIN:   state_next = S_MUL_LO;
      S_MUL_LO:  state_next = S_MUL_HI;
      S_MUL_HI:  state_next = S_SUM;
      S_SUM:     state_next = S_FIN;
      S_FIN:     state_next = S_IDLE;
      S_COPY:    state_next = S_COPY_WB;
      S_COPY_WB: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    we        = 1'b0;
    wr_addr   = {~bsel, cur.idx_c[CW-1:0]};
    wr_data   = total_val;
    rd_addr_a = {bsel, sel_a[CW-1:0]};
    rd_addr_b = {bsel, sel_b[CW-1:0]};
    unique case (state)
      S_IDLE: begin
        pop     = !q_empty && !out_vld;
        we      = pop && (q_head.kind == K_LOAD);
        wr_addr = {bsel, q_head.idx_c[CW-1:0]};
        wr_data = q_head.value;
      end
      S_COPY:    rd_addr_a = {bsel, cur.idx_c[CW-1:0]};
      S_COPY_WB: begin
        we      = 1'b1;
        wr_data = rd_a;
      end
      S_FIN:     we = 1'b1;
      default:   ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bsel     <= 1'b0;
      out_vld  <= 1'b0;
      acc_vld  <= 1'b0;
      rd_cnt   <= 3'd0;
    end else begin
      state   <= state_next;
      acc_vld <= (state == S_READ);
      if (out_vld && out_rdy) out_vld <= 1'b0;
      if (state == S_READ) rd_cnt <= rd_cnt + 3'd1;
      if (pop) begin
        rd_cnt <= 3'd0;
        if (q_head.kind == K_COMMIT) bsel <= ~bsel;
        if (q_head.kind != K_STENCIL && q_head.kind != K_COPY) out_vld <= 1'b1;
      end
      if (state == S_FIN || state == S_COPY_WB) out_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    acc_pair <= rd_cnt;
    if (pop) begin
      cur <= q_head;
      case (q_head.kind)
        K_LOAD, K_ECHO: out_value <= q_head.value;
        default:        out_value <= '0;
      endcase
      out_sat <= 1'b0;
    end
    if (acc_vld) begin
      acc <= ((acc_pair == 3'd0) ? '0 : acc) + term(rd_a, wa) + term(rd_b, wb);
      if (acc_pair == 3'd0) c_reg <= $signed(rd_a);
    end
    if (state == S_MUL_LO) prod_lo <= 43'(acc[18:0]) * 43'(scale_factor);
    if (state == S_MUL_HI) prod_hi <= 44'($signed(acc[ACC_W-1:19])) * $signed({20'd0, scale_factor});
    if (state == S_SUM)    prod    <= (63'(prod_hi) <<< 19) + $signed(63'(prod_lo));
    if (state == S_FIN) begin
      out_value <= total_val;
      out_sat   <= total_sat;
    end
    if (state == S_COPY_WB) begin
      out_value <= rd_a;
      out_sat   <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/nine_point_diffusion_step_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_point_diffusion_step_core
// explicit nine-point diffusion step on a double-buffered lattice
// ----------------------------------------------------------------------------
// A user first loads cells, then sends compute items and a commit to swap
// buffers. Every accepted transaction gives exactly one result transaction.
// Loads, commits, unused codes and out-of-lattice items leave the back end
// in the cycle after leaving the queue; an edge cell without wrap passes the
// copy and copy write-back states; a full stencil reads its nine cells in
// pairs on the two read ports of the lattice memory, then runs the split 38
// by 24 bit multiply and the final sum and clamp. A two-entry queue lets new
// transactions in while the back end works. Lattice contents are undefined
// until loaded: no clearing pass runs after reset.
module nine_point_diffusion_step_core import ndiff_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cell_x, cell_y, cell_value, half_step, zero fill
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value
  output logic [0:0]  m_tuser,   // saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [6:0]  size_x, size_y;
  logic        periodic_wrap;
  logic [23:0] scale_factor;

  entry_t in_entry, q_head;
  logic   q_full, q_empty, push, pop, busy;

  // configuration, taken every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x        <= 7'd64;
      size_y        <= 7'd64;
      periodic_wrap <= 1'b0;
      scale_factor  <= 24'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIZE_X: size_x        <= cfg_data[6:0];
        CFG_SIZE_Y: size_y        <= cfg_data[6:0];
        CFG_WRAP:   periodic_wrap <= cfg_data[0];
        CFG_SCALE:  scale_factor  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // front: classify and index
  ndiff_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_front (
    .op            (s_tuser),
    .cell_x        (s_tdata[5:0]),
    .cell_y        (s_tdata[11:6]),
    .cell_value    (s_tdata[43:12]),
    .half_step     (s_tdata[44]),
    .size_x        (size_x),
    .size_y        (size_y),
    .periodic_wrap (periodic_wrap),
    .entry         (in_entry)
  );

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  ndiff_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (in_entry),
    .pop        (pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // back: lattice memory, arithmetic and result register
  ndiff_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .pop          (pop),
    .busy         (busy),
    .scale_factor (scale_factor),
    .out_vld      (m_tvalid),
    .out_rdy      (m_tready),
    .out_value    (m_tdata),
    .out_sat      (m_tuser[0])
  );

  // result register stays empty while the back end works on an item
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    busy |-> !m_tvalid) else $error("result pending while back end busy");

  // a pop only happens from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty) else $error("pop from empty queue");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result valid after reset");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the nine-point diffusion step core
// ----------------------------------------------------------------------------
// Keeps its own copy of both lattice buffers, the buffer select bit and the
// registers, and predicts every result word and its saturation flag. The
// input is driven in random bursts and the output is stalled on a pattern of
// its own. Once, the output is held off for a long stretch. Computes that
// would read a cell never loaded are turned into loads of that cell.
// ----------------------------------------------------------------------------
module tb;
  import ndiff_pkg::*;

  localparam int LAT_X = 64;
  localparam int LAT_Y = 64;

  class diffusion_scoreboard;
    logic [31:0] lattice [2][LAT_X*LAT_Y];
    bit          loaded  [2][LAT_X*LAT_Y];
    bit          swap_sel;
    int          reg_sx, reg_sy;
    bit          reg_wrap;
    logic [23:0] reg_scale;
    logic [32:0] expected_q [$];
    int          errors;
    int          accepted;

    function new();
      swap_sel = 0;
      reg_sx = 64;
      reg_sy = 64;
      reg_wrap = 0;
      reg_scale = '0;
      errors = 0;
      accepted = 0;
    endfunction

    function int used_x();
      return reg_sx < 3 ? 3 : (reg_sx > LAT_X ? LAT_X : reg_sx);
    endfunction

    function int used_y();
      return reg_sy < 3 ? 3 : (reg_sy > LAT_Y ? LAT_Y : reg_sy);
    endfunction

    function void write_reg(logic [7:0] idx, logic [23:0] d);
      case (idx)
        CFG_SIZE_X: reg_sx = d[6:0];
        CFG_SIZE_Y: reg_sy = d[6:0];
        CFG_WRAP:   reg_wrap = d[0];
        CFG_SCALE:  reg_scale = d;
        default: ;
      endcase
    endfunction

    // neighbour index with periodic wrap; interior cells never wrap
    function int nb(int x, int y, int dx, int dy);
      return ((y + dy + used_y()) % used_y()) * LAT_X + (x + dx + used_x()) % used_x();
    endfunction

    function bit is_edge(int x, int y);
      return x == 0 || y == 0 || x == used_x() - 1 || y == used_y() - 1;
    endfunction

    // first cell a compute at (x,y) would read that was never written, or -1
    function int missing_cell(int x, int y);
      int dx, dy, i;
      if (x >= used_x() || y >= used_y()) return -1;
      if (!loaded[swap_sel][y*LAT_X+x]) return y*LAT_X + x;
      if (is_edge(x, y) && !reg_wrap) return -1;
      for (dy = -1; dy <= 1; dy++)
        for (dx = -1; dx <= 1; dx++) begin
          i = nb(x, y, dx, dy);
          if (!loaded[swap_sel][i]) return i;
        end
      return -1;
    endfunction

    function longint cell_val(int i);
      return longint'($signed(lattice[swap_sel][i]));
    endfunction

    function void note_input(logic [1:0] op, int x, int y, logic [31:0] val, bit half);
      bit          in_lattice;
      bit          sat;
      longint      c, lap, prod, r;
      int          ci;
      in_lattice = x < used_x() && y < used_y();
      ci = y*LAT_X + x;
      sat = 0;
      accepted++;
      case (op)
        OP_LOAD: begin
          if (in_lattice) begin
            lattice[swap_sel][ci] = val;
            loaded[swap_sel][ci] = 1;
          end
          expected_q.push_back({1'b0, val});
        end
        OP_COMPUTE: begin
          if (!in_lattice) begin
            expected_q.push_back('0);
          end else begin
            c = cell_val(ci);
            r = c;
            if (!is_edge(x, y) || reg_wrap) begin
              lap = -20*c + 4*(cell_val(nb(x,y,-1,0)) + cell_val(nb(x,y,1,0))
                    + cell_val(nb(x,y,0,-1)) + cell_val(nb(x,y,0,1)))
                    + cell_val(nb(x,y,1,1)) + cell_val(nb(x,y,-1,1))
                    + cell_val(nb(x,y,1,-1)) + cell_val(nb(x,y,-1,-1));
              prod = lap * longint'({40'd0, reg_scale});
              r = c + (prod >>> (half ? 17 : 16));
            end
            if (r > 64'sd2147483647) begin
              r = 64'sd2147483647;
              sat = 1;
            end
            if (r < -64'sd2147483648) begin
              r = -64'sd2147483648;
              sat = 1;
            end
            lattice[!swap_sel][ci] = r[31:0];
            loaded[!swap_sel][ci] = 1;
            expected_q.push_back({sat, r[31:0]});
          end
        end
        OP_COMMIT: begin
          swap_sel = !swap_sel;
          expected_q.push_back('0);
        end
        default: expected_q.push_back('0);
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [31:0] val, logic sat);
      logic [32:0] e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", val));
        return;
      end
      e = expected_q.pop_front();
      if (val !== e[31:0]) report($sformatf("value %h, wanted %h", val, e[31:0]));
      if (sat !== e[32]) report($sformatf("saturated %b, wanted %b", sat, e[32]));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  diffusion_scoreboard sb = new();
  int  burst_left = 0;
  int  cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  nine_point_diffusion_step_core dut (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one long hold-off of the output, so the input queue fills and stalls
  always @(posedge clk) begin
    if (!hold_done && sb.accepted >= 350) begin
      hold_left <= 400;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output stall pattern: free running, light and heavy stall windows
  always @(posedge clk) begin
    if (rst || hold_left > 0) begin
      m_tready <= 0;
    end else begin
      case ((cycles / 700) % 3)
        0: m_tready <= 1;
        1: m_tready <= ($urandom % 4) != 0;
        default: m_tready <= ($urandom % 10) < 3;
      endcase
    end
  end

  // result transactions
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
  end

  task send(logic [1:0] op, int x, int y, logic [31:0] val, bit half);
    s_tdata  <= {3'b000, half, val, y[5:0], x[5:0]};
    s_tuser  <= op;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, x, y, val, half);
    if (burst_left == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task write_cfg(logic [7:0] idx, logic [23:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task wait_idle();
    s_tvalid <= 0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // stencil back end plus queue
    repeat (40) @(posedge clk);
  endtask

  function logic [31:0] rand_value();
    case ($urandom % 4)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return ($urandom % 2) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // mostly well-formed: computes whose inputs are loaded, else loads that fill
  task rand_item();
    int          r, x, y, m;
    logic [1:0]  op;
    r = $urandom % 100;
    if (($urandom % 10) == 0) begin
      x = $urandom_range(0, 63);
      y = $urandom_range(0, 63);
    end else begin
      x = $urandom_range(0, sb.used_x() - 1);
      y = $urandom_range(0, sb.used_y() - 1);
    end
    op = r < 30 ? OP_LOAD : r < 90 ? OP_COMPUTE : r < 96 ? OP_COMMIT : OP_UNUSED;
    if (op == OP_COMPUTE) begin
      m = sb.missing_cell(x, y);
      if (m >= 0) begin
        op = OP_LOAD;
        x = m % LAT_X;
        y = m / LAT_X;
      end
    end
    send(op, x, y, rand_value(), 1'($urandom % 2));
  endtask

  initial begin
    int          ph, i, n;
    logic [23:0] scales [4];
    scales = '{24'd0, 24'hffffff, 24'h000400, 24'h004000};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: 4x4 lattice, no wrap, largest scale
    write_cfg(CFG_SIZE_X, 24'd4);
    write_cfg(CFG_SIZE_Y, 24'd4);
    write_cfg(CFG_WRAP, 24'd0);
    write_cfg(CFG_SCALE, 24'hffffff);
    for (i = 0; i < 16; i++)
      send(OP_LOAD, i % 4, i / 4, i == 5 ? 32'h8000_0000 : i == 6 ? 32'h7fff_ffff :
           i == 10 ? 32'h0 : 32'h7fff_0000 - i, i[0]);
    send(OP_COMPUTE, 1, 1, 32'h0, 0);      // saturates high
    send(OP_COMPUTE, 2, 2, 32'hffff_ffff, 1);
    send(OP_COMPUTE, 0, 0, 32'h0, 0);      // edge cell copied
    send(OP_COMPUTE, 63, 63, 32'h0, 1);    // outside the lattice
    send(OP_LOAD, 5, 63, 32'hdead_beef, 1);
    send(OP_UNUSED, 63, 63, 32'hffff_ffff, 1);
    send(OP_COMMIT, 0, 0, 32'h0, 0);
    wait_idle();

    // random phases, several register settings including the extremes
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          write_cfg(CFG_SIZE_X, 24'd0);
          write_cfg(CFG_SIZE_Y, 24'd3);
        end
        1: begin
          write_cfg(CFG_SIZE_X, 24'hffff80 | 24'd127);
          write_cfg(CFG_SIZE_Y, 24'd2);
        end
        2: begin
          write_cfg(CFG_SIZE_X, 24'd5);
          write_cfg(CFG_SIZE_Y, 24'd64);
        end
        default: begin
          write_cfg(CFG_SIZE_X, 24'($urandom_range(3, 8)));
          write_cfg(CFG_SIZE_Y, 24'($urandom_range(3, 8)));
        end
      endcase
      write_cfg(CFG_WRAP, ph % 2 ? 24'd1 : (24'($urandom) & 24'hfffffe) | 24'(ph > 4));
      write_cfg(CFG_SCALE, ph < 4 ? scales[ph] : 24'($urandom));
      n = 90;
      for (i = 0; i < n; i++) rand_item();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ndiff_pkg.sv
rtl/core/ndiff_front.sv
rtl/core/ndiff_queue.sv
rtl/core/ndiff_back.sv
rtl/core/nine_point_diffusion_step_core.sv
test/tb.sv
